// ===== design/mfap_pkg.sv =====
// Shared types and constants of the augmenting-path max-flow engine.
package mfap_pkg;

   // Fixed widths of the stream payloads.
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;
   localparam int FLOW_W      = 22;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE       = 2'd1;
   localparam int                   CSR_SINK         = 2;

   // Request kinds carried in tuser.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_RUN   = 1'b1;

   // Controller states.
   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_SINIT,
      ST_POP,
      ST_POPW,
      ST_SCAN,
      ST_BPAR,
      ST_BRD,
      ST_BCMP,
      ST_UPAR,
      ST_URD,
      ST_UFWD,
      ST_UREV,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic cap_write;
      logic run_start;
      logic copy_step;
      logic search_init;
      logic pop;
      logic load_u;
      logic scan_step;
      logic par_read;
      logic res_read_uv;
      logic bn_update;
      logic walk_start;
      logic bn_reset;
      logic fwd_write;
      logic rev_write;
      logic flow_add;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_run;
      logic sweep_last;
      logic trivial;
      logic copy_done;
      logic stack_empty;
      logic sink_reached;
      logic scan_done;
      logic u_is_src;
      logic out_free;
   } sts_type;

endpackage

// ===== design/mfap_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mfap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mfap_ctrl.sv =====
// Controller state machine of the augmenting-path max-flow engine.
module mfap_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  mfap_pkg::sts_type sts,
   output mfap_pkg::cmd_type cmd
);
   import mfap_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (sts.req_run == ACT_RUN) begin
                  cmd.run_start = 1'b1;
                  state_in      = sts.trivial ? ST_FINISH : ST_COPY;
               end else begin
                  cmd.cap_write = 1'b1;
               end
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (sts.copy_done) begin
               state_in = ST_SINIT;
            end
         end
         ST_SINIT: begin
            cmd.search_init = 1'b1;
            state_in        = ST_POP;
         end
         ST_POP: begin
            if (sts.stack_empty) begin
               if (sts.sink_reached) begin
                  cmd.walk_start = 1'b1;
                  cmd.bn_reset   = 1'b1;
                  state_in       = ST_BPAR;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_POPW;
            end
         end
         ST_POPW: begin
            cmd.load_u = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_POP;
            end
         end
         ST_BPAR: begin
            cmd.par_read = 1'b1;
            state_in     = ST_BRD;
         end
         ST_BRD: begin
            cmd.res_read_uv = 1'b1;
            state_in        = ST_BCMP;
         end
         ST_BCMP: begin
            cmd.bn_update = 1'b1;
            if (sts.u_is_src) begin
               cmd.walk_start = 1'b1;
               state_in       = ST_UPAR;
            end else begin
               state_in = ST_BPAR;
            end
         end
         ST_UPAR: begin
            cmd.par_read = 1'b1;
            state_in     = ST_URD;
         end
         ST_URD: begin
            cmd.res_read_uv = 1'b1;
            state_in        = ST_UFWD;
         end
         ST_UFWD: begin
            cmd.fwd_write = 1'b1;
            state_in      = ST_UREV;
         end
         ST_UREV: begin
            cmd.rev_write = 1'b1;
            if (sts.u_is_src) begin
               cmd.flow_add = 1'b1;
               state_in     = ST_SINIT;
            end else begin
               state_in = ST_UPAR;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/mfap_dp.sv =====
// Datapath: capacity and residual stores, search stack, parents and flow.
module mfap_dp #(
   parameter int MAX_VERTICES = 64,
   parameter int CAP_BITS     = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mfap_pkg::cmd_type                     cmd,
   output mfap_pkg::sts_type                     sts,
   input  logic [mfap_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mfap_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mfap_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mfap_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tuser
);
   import mfap_pkg::*;

   localparam int VW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
   localparam int NW = VW + 1;
   localparam int AW = 2 * VW;
   localparam int CW = (CAP_BITS < 16) ? CAP_BITS : 16;
   localparam int RW = CW + 1;

   // Request fields.
   logic [5:0]  req_from;
   logic [5:0]  req_to;
   logic [15:0] req_cap;
   assign req_from = req_tdata[5:0];
   assign req_to   = req_tdata[11:6];
   assign req_cap  = req_tdata[27:12];

   // Configuration registers.
   logic [6:0] vcount_ff, vcount_in;
   logic [5:0] src_ff, src_in;
   logic [5:0] dst_ff, dst_in;

   assign csr_ready = 1'b1;

   always_comb begin
      vcount_in = vcount_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:           vcount_in = csr_data;
            CSR_SOURCE:                 src_in    = csr_data[5:0];
            CSR_IDX_W'(CSR_SINK):       dst_in    = csr_data[5:0];
            default:                    vcount_in = vcount_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 7'd64;
         src_ff    <= 6'd0;
         dst_ff    <= 6'd1;
      end else begin
         vcount_ff <= vcount_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
      end
   end

   // Live vertex count, saturated into the supported range.
   logic [NW-1:0] n_w;
   logic [VW-1:0] src_v;
   logic [VW-1:0] dst_v;
   always_comb begin
      if (vcount_ff < 7'd2) begin
         n_w = NW'(2);
      end else if (int'(vcount_ff) > MAX_VERTICES) begin
         n_w = NW'(MAX_VERTICES);
      end else begin
         n_w = NW'(vcount_ff);
      end
   end
   assign src_v = VW'(src_ff);
   assign dst_v = VW'(dst_ff);

   // Working registers.
   logic [AW:0]        cnt_ff, cnt_in;
   logic [AW-1:0]      cnt_d_ff, cnt_d_in;
   logic               cpend_ff, cpend_in;
   logic [NW-1:0]      depth_ff, depth_in;
   logic [VW-1:0]      u_ff, u_in;
   logic [VW-1:0]      v_ff, v_in;
   logic [NW-1:0]      i_ff, i_in;
   logic               ev_valid_ff, ev_valid_in;
   logic [VW-1:0]      ev_idx_ff, ev_idx_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [RW-1:0]      bneck_ff, bneck_in;
   logic [FLOW_W-1:0]  flow_ff, flow_in;
   logic               run_status_ff, run_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FLOW_W-1:0]  rsp_flow_ff, rsp_flow_in;
   logic               rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic          cap_we;
   logic [AW-1:0] cap_waddr;
   logic [CW-1:0] cap_wdata;
   logic [CW-1:0] cap_rdata;
   logic          res_we;
   logic [AW-1:0] res_waddr;
   logic [RW-1:0] res_wdata;
   logic [AW-1:0] res_raddr;
   logic [RW-1:0] res_rdata;
   logic          stk_we;
   logic [VW-1:0] stk_waddr;
   logic [VW-1:0] stk_wdata;
   logic [VW-1:0] stk_raddr;
   logic [VW-1:0] stk_rdata;
   logic [VW-1:0] par_rdata;
   logic          push;
   logic          wr_in_range;

   assign wr_in_range = (int'(req_from) < MAX_VERTICES) && (int'(req_to) < MAX_VERTICES);

   // A scanned neighbor is pushed when unvisited and reachable, and the stack is not full.
   assign push = cmd.scan_step && ev_valid_ff && !visited_ff[ev_idx_ff]
                 && (res_rdata != '0) && (int'(depth_ff) < MAX_VERTICES);

   // Capacity store: clearing sweep and entry writes.
   assign cap_we    = cmd.clr_step || (cmd.cap_write && wr_in_range);
   assign cap_waddr = cmd.clr_step ? cnt_ff[AW-1:0] : {VW'(req_from), VW'(req_to)};
   assign cap_wdata = cmd.clr_step ? '0 : CW'(req_cap);

   // Residual store port selection.
   always_comb begin
      res_raddr = '0;
      if (cmd.scan_step) begin
         res_raddr = {u_ff, i_ff[VW-1:0]};
      end else if (cmd.res_read_uv) begin
         res_raddr = {par_rdata, v_ff};
      end else if (cmd.fwd_write) begin
         res_raddr = {v_ff, u_ff};
      end
      res_we    = 1'b0;
      res_waddr = cnt_d_ff;
      res_wdata = RW'(cap_rdata);
      if (cmd.copy_step && cpend_ff) begin
         res_we = 1'b1;
      end else if (cmd.fwd_write) begin
         res_we    = 1'b1;
         res_waddr = {u_ff, v_ff};
         res_wdata = res_rdata - bneck_ff;
      end else if (cmd.rev_write) begin
         res_we    = 1'b1;
         res_waddr = {v_ff, u_ff};
         res_wdata = res_rdata + bneck_ff;
      end
   end

   // Stack port selection.
   assign stk_we    = cmd.search_init || push;
   assign stk_waddr = cmd.search_init ? '0 : depth_ff[VW-1:0];
   assign stk_wdata = cmd.search_init ? src_v : ev_idx_ff;
   assign stk_raddr = VW'(depth_ff - NW'(1));

   // Next values of the working registers.
   always_comb begin
      cnt_in        = cnt_ff;
      cnt_d_in      = cnt_d_ff;
      cpend_in      = cpend_ff;
      depth_in      = depth_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      i_in          = i_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      visited_in    = visited_ff;
      bneck_in      = bneck_ff;
      flow_in       = flow_ff;
      run_status_in = run_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_flow_in   = rsp_flow_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.clr_step) begin
         cnt_in = cnt_ff + (AW+1)'(1);
      end
      if (cmd.run_start) begin
         cnt_in        = '0;
         cpend_in      = 1'b0;
         flow_in       = '0;
         run_status_in = (src_ff == dst_ff);
      end
      // Copy sweep: read one capacity entry, write it in the following cycle.
      if (cmd.copy_step) begin
         cpend_in = !cnt_ff[AW];
         cnt_d_in = cnt_ff[AW-1:0];
         if (!cnt_ff[AW]) begin
            cnt_in = cnt_ff + (AW+1)'(1);
         end
      end
      if (cmd.search_init) begin
         visited_in        = '0;
         visited_in[src_v] = 1'b1;
         depth_in          = NW'(1);
      end
      if (cmd.pop) begin
         depth_in = depth_ff - NW'(1);
      end
      if (cmd.load_u) begin
         u_in        = stk_rdata;
         i_in        = '0;
         ev_valid_in = 1'b0;
      end
      // Neighbor scan: issue one read, judge the previous one.
      if (cmd.scan_step) begin
         if (i_ff < n_w) begin
            i_in        = i_ff + NW'(1);
            ev_valid_in = 1'b1;
            ev_idx_in   = i_ff[VW-1:0];
         end else begin
            ev_valid_in = 1'b0;
         end
         if (push) begin
            visited_in[ev_idx_ff] = 1'b1;
            depth_in              = depth_ff + NW'(1);
         end
      end
      if (cmd.bn_reset) begin
         bneck_in = '1;
      end
      if (cmd.res_read_uv) begin
         u_in = par_rdata;
      end
      if (cmd.bn_update) begin
         if (res_rdata < bneck_ff) begin
            bneck_in = res_rdata;
         end
         v_in = u_ff;
      end
      if (cmd.rev_write) begin
         v_in = u_ff;
      end
      // A new walk restarts at the sink, even on the last bottleneck step.
      if (cmd.walk_start) begin
         v_in = dst_v;
      end
      if (cmd.flow_add) begin
         flow_in = flow_ff + FLOW_W'(bneck_ff);
      end
      // Output register.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_flow_in   = flow_ff;
         rsp_status_in = run_status_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cpend_ff     <= 1'b0;
         depth_ff     <= '0;
         i_ff         <= '0;
         ev_valid_ff  <= 1'b0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         cpend_ff     <= cpend_in;
         depth_ff     <= depth_in;
         i_ff         <= i_in;
         ev_valid_ff  <= ev_valid_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_d_ff      <= cnt_d_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      ev_idx_ff     <= ev_idx_in;
      bneck_ff      <= bneck_in;
      flow_ff       <= flow_in;
      run_status_ff <= run_status_in;
      rsp_flow_ff   <= rsp_flow_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Stores.
   mfap_ram #(.WIDTH(CW), .DEPTH(1 << AW)) u_cap_ram (
      .clock   (clock),
      .wr_en   (cap_we),
      .wr_addr (cap_waddr),
      .wr_data (cap_wdata),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (cap_rdata)
   );

   mfap_ram #(.WIDTH(RW), .DEPTH(1 << AW)) u_res_ram (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (res_waddr),
      .wr_data (res_wdata),
      .rd_addr (res_raddr),
      .rd_data (res_rdata)
   );

   mfap_ram #(.WIDTH(VW), .DEPTH(1 << VW)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   mfap_ram #(.WIDTH(VW), .DEPTH(1 << VW)) u_parent_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (ev_idx_ff),
      .wr_data (u_ff),
      .rd_addr (v_ff),
      .rd_data (par_rdata)
   );

   // Status to the controller.
   always_comb begin
      sts.req_run      = req_tuser;
      sts.sweep_last   = (cnt_ff[AW-1:0] == '1);
      sts.trivial      = (src_ff == dst_ff) || (int'(src_ff) >= int'(n_w))
                         || (int'(dst_ff) >= int'(n_w));
      sts.copy_done    = cnt_ff[AW] && !cpend_ff;
      sts.stack_empty  = (depth_ff == '0);
      sts.sink_reached = visited_ff[dst_v];
      sts.scan_done    = (i_ff == n_w) && !ev_valid_ff;
      sts.u_is_src     = (u_ff == src_v);
      sts.out_free     = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_flow_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== design/max_flow_augmenting_path.sv =====
// Top level of the augmenting-path max-flow engine.
// A write transaction (tuser 0) stores one capacity entry; a run transaction (tuser 1)
// returns one result with the maximum flow from the source to the sink vertex. After reset
// the capacity store is swept to zero, one entry per cycle, while no transaction is taken;
// configuration writes are taken throughout. A run copies the whole store into the residual
// store (about one entry per cycle), then repeats a depth-first search over the reachable
// vertices, a bottleneck walk and an update walk along the found path, until no path remains;
// its length is set by the single read port of the residual memory and grows with the
// number of augmenting paths.
module max_flow_augmenting_path #(
   parameter int MAX_VERTICES = 64,
   parameter int CAP_BITS     = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: from_vertex[5:0], to_vertex[11:6], capacity[27:12], zero pad.
   input  logic [mfap_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // Fields: action[0].
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: max_flow[21:0], zero pad.
   output logic [mfap_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // Fields: status[0].
   output logic                                 rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mfap_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mfap_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mfap_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Controller.
   mfap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath.
   mfap_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .CAP_BITS     (CAP_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // A result flagged for source equal to sink carries zero flow.
   a_flag_zero_flow: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("flagged result carries nonzero flow");

   // No request transaction is taken right after reset, while the store is swept.
   a_sweep_blocks: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("request taken during clearing sweep");

   // Loading the output register always presents a result next cycle.
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("loaded result not presented");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the augmenting-path max-flow engine: loads, runs and flow checks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mfap_pkg::*;

   localparam int NV = 64;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   max_flow_augmenting_path dut (.*);

   // Expected result of one run.
   typedef struct packed {
      logic [FLOW_W-1:0] flow;
      logic              same_ends;
   } flow_result_t;

   // One row of the directed table; chk marks a hand-typed expectation.
   typedef struct {
      logic        act;
      int          from_v;
      int          to_v;
      int          cap;
      bit          chk;
      int          flow;
      bit          same;
   } load_row_t;

   // Predictor copy of the state.
   int unsigned cap_mat [NV*NV];
   longint      res_mat [NV*NV];
   int          parent_of [NV];
   bit          seen [NV];
   int          vcount_reg;
   int          src_reg;
   int          snk_reg;

   flow_result_t pending_flows[$];
   int           error_count;
   int           runs_checked;
   int           items_sent;
   int           send_idle_pct;
   int           recv_stall_pct;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog.
   initial begin
      #2s;
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Depth-first path search over positive residuals.
   function automatic bit search_path(int n, int s, int d);
      int stk [NV];
      int depth;
      int u;
      depth = 0;
      for (int i = 0; i < NV; i++) seen[i] = 0;
      seen[s] = 1;
      stk[depth++] = s;
      while (depth > 0) begin
         u = stk[--depth];
         for (int i = 0; i < n; i++) begin
            if (!seen[i] && res_mat[u*NV+i] != 0 && depth < NV) begin
               seen[i] = 1;
               parent_of[i] = u;
               stk[depth++] = i;
            end
         end
      end
      return seen[d];
   endfunction

   // Maximum flow from the current matrix and registers.
   function automatic flow_result_t compute_max_flow();
      flow_result_t r;
      int n;
      longint flow;
      longint bn;
      int u;
      n = vcount_reg < 2 ? 2 : (vcount_reg > NV ? NV : vcount_reg);
      r = '0;
      if (src_reg == snk_reg) begin
         r.same_ends = 1'b1;
         return r;
      end
      if (src_reg >= n || snk_reg >= n) return r;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) res_mat[i*NV+j] = cap_mat[i*NV+j];
      flow = 0;
      while (search_path(n, src_reg, snk_reg)) begin
         bn = 64'h7FFF_FFFF;
         for (int v = snk_reg; v != src_reg; v = parent_of[v]) begin
            u = parent_of[v];
            if (res_mat[u*NV+v] < bn) bn = res_mat[u*NV+v];
         end
         for (int v = snk_reg; v != src_reg; v = parent_of[v]) begin
            u = parent_of[v];
            res_mat[u*NV+v] -= bn;
            res_mat[v*NV+u] += bn;
         end
         flow += bn;
      end
      r.flow = flow[FLOW_W-1:0];
      return r;
   endfunction

   // Drive one request transaction and update the predictor on acceptance.
   // Valid stays high afterwards so that transactions can follow back to back.
   task automatic send_item(input logic act, input int f, input int t, input int c);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'd0, c[15:0], t[5:0], f[5:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (act == ACT_WRITE) cap_mat[f*NV+t] = c[15:0];
      else pending_flows.push_back(compute_max_flow());
   endtask

   // Stop sending, wait for all runs to report, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_flows.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Configuration write transaction; only used while idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_VERTEX_COUNT) vcount_reg = val & 8'h7F;
      else if (idx == CSR_SOURCE) src_reg = val & 8'h3F;
      else snk_reg = val & 8'h3F;
   endtask

   task automatic set_graph_regs(input int n, input int s, input int d);
      write_csr(CSR_VERTEX_COUNT, n);
      write_csr(CSR_SOURCE, s);
      write_csr(CSR_SINK[CSR_IDX_W-1:0], d);
      csr_valid <= 1'b0;
   endtask

   // Receiver side: random stall, compare against the oldest expectation.
   always @(posedge clock) begin
      flow_result_t w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_flows.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, -1);
            end else begin
               w = pending_flows.pop_front();
               runs_checked++;
               if (rsp_tdata[FLOW_W-1:0] != w.flow)
                  report_mismatch("max_flow", rsp_tdata[FLOW_W-1:0], w.flow);
               if (rsp_tdata[RSP_TDATA_W-1:FLOW_W] != '0)
                  report_mismatch("pad", rsp_tdata[RSP_TDATA_W-1:FLOW_W], 0);
               if (rsp_tuser != w.same_ends)
                  report_mismatch("status", rsp_tuser, w.same_ends);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Stimulus.
   initial begin
      load_row_t dir_rows[$];
      int ph_n;
      int ph_s;
      int ph_d;
      int nphase;
      int f;
      int t;
      error_count = 0;
      runs_checked = 0;
      items_sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_WRITE;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      vcount_reg = 64;
      src_reg = 0;
      snk_reg = 1;
      for (int i = 0; i < NV*NV; i++) cap_mat[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table: empty graph, a single edge at full capacity, extreme
      // corners, self loop, parallel paths and an ignored run payload.
      dir_rows = '{
         '{ACT_RUN,   0,  0,     0, 1,     0, 0},
         '{ACT_WRITE, 0,  1, 65535, 0,     0, 0},
         '{ACT_RUN,  63, 63, 65535, 1, 65535, 0},
         '{ACT_WRITE, 0,  0,  1000, 0,     0, 0},
         '{ACT_WRITE, 1,  1,  1000, 0,     0, 0},
         '{ACT_RUN,   0,  0,     0, 1, 65535, 0},
         '{ACT_WRITE, 0,  2,     7, 0,     0, 0},
         '{ACT_WRITE, 2,  1,     5, 0,     0, 0},
         '{ACT_WRITE, 0,  3,    40, 0,     0, 0},
         '{ACT_WRITE, 3, 63,    40, 0,     0, 0},
         '{ACT_WRITE,63,  1,    30, 0,     0, 0},
         '{ACT_WRITE, 1,  0,   999, 0,     0, 0},
         '{ACT_RUN,   0,  0,     0, 0,     0, 0},
         '{ACT_WRITE, 0,  1,     0, 0,     0, 0},
         '{ACT_WRITE,63,  0,    12, 0,     0, 0},
         '{ACT_RUN,  21, 42, 43690, 0,     0, 0}
      };
      foreach (dir_rows[k]) begin
         if (dir_rows[k].chk) begin
            send_item(dir_rows[k].act, dir_rows[k].from_v, dir_rows[k].to_v, dir_rows[k].cap);
            if (pending_flows[$].flow != dir_rows[k].flow[FLOW_W-1:0]
                || pending_flows[$].same_ends != dir_rows[k].same)
               report_mismatch("table row", k, dir_rows[k].flow);
         end else begin
            send_item(dir_rows[k].act, dir_rows[k].from_v, dir_rows[k].to_v, dir_rows[k].cap);
         end
      end
      drain();

      // Register extremes: source equals sink, ends beyond n, n below and above range.
      set_graph_regs(64, 5, 5);
      send_item(ACT_RUN, 0, 0, 0);
      drain();
      set_graph_regs(2, 0, 63);
      send_item(ACT_RUN, 0, 0, 0);
      drain();
      set_graph_regs(0, 1, 0);
      send_item(ACT_RUN, 0, 0, 0);
      drain();
      set_graph_regs(127, 63, 0);
      send_item(ACT_RUN, 0, 0, 0);
      drain();

      // Random phases: small graphs mostly, different idling per phase.
      nphase = 0;
      while (items_sent < 560) begin
         case (nphase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         ph_n = (nphase % 7 == 6) ? 64 : $urandom_range(2, 10);
         if (nphase % 9 == 8) ph_n = $urandom_range(0, 127);
         ph_s = $urandom_range(0, 63);
         ph_d = $urandom_range(0, 63);
         if ($urandom_range(9) < 8) begin
            ph_s = $urandom_range(0, (ph_n < 2 ? 2 : (ph_n > 64 ? 64 : ph_n)) - 1);
            ph_d = $urandom_range(0, (ph_n < 2 ? 2 : (ph_n > 64 ? 64 : ph_n)) - 1);
         end
         set_graph_regs(ph_n, ph_s, ph_d);
         for (int b = 0; b < 5; b++) begin
            repeat ($urandom_range(4, 14)) begin
               f = $urandom_range(0, 63);
               t = $urandom_range(0, 63);
               if ($urandom_range(9) < 8 && ph_n >= 2 && ph_n <= 64) begin
                  f = $urandom_range(0, ph_n - 1);
                  t = $urandom_range(0, ph_n - 1);
               end
               send_item(ACT_WRITE, f, t,
                         $urandom_range(3) == 0 ? $urandom_range(0, 65535) :
                         ($urandom_range(5) == 0 ? 0 : $urandom_range(1, 300)));
            end
            send_item(ACT_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 65535));
         end
         // Hold off the sender once until every run has reported.
         if (nphase == 2) begin
            drain();
         end
         drain();
         nphase++;
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      $display("Covered %0d transactions, %0d flow results checked over %0d phases.",
               items_sent, runs_checked, nphase);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
